>>> design/assert_macros.svh
// Assertion macros used by the record table design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_CLK_RST(label, clk, prop, msg)
`endif
`endif

>>> design/skrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrt_pkg
// Types and constants of the sorted keyed record table.
// ----------------------------------------------------------------------------
package skrt_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_ADDQ   = 3'd2;
    localparam logic [2:0] ACT_SETP   = 3'd3;
    localparam logic [2:0] ACT_DELETE = 3'd4;
    localparam logic [2:0] ACT_LIST   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam int REC_W = 16 + 32 + 24;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] qty;
        logic [23:0] price;
    } rec_t;
endpackage

>>> design/skrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module skrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> design/sorted_keyed_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyed_record_table
// Sorted record table with insert, search, update, delete and list actions.
// ----------------------------------------------------------------------------
// Records live in one single-port RAM in ascending key order and are handled
// by a sequencer that touches one entry a cycle through that port. A search
// scans from entry 0, reading and then comparing each entry examined; insert
// and delete then shift the tail one entry at a time (read, write). List
// reads and sends the records one by one while the receiver keeps up.
// s_tready is high only while the sequencer idles. Results leave through an
// output register, so the block waits for m_tready before taking a new item.
`include "assert_macros.svh"

module sorted_keyed_record_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] action, [18:3] product_key, [50:19] quantity_value,
    // [75:51] price_value
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [18:3] record_key, [50:19] record_quantity,
    // [74:51] record_price
    output logic [79:0] m_tdata,
    output logic        m_tlast
);
    localparam int IW = skrt_pkg::IDX_W;
    localparam int CW = skrt_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCMP, S_DECIDE, S_IRD, S_IWR, S_DRD, S_DWR,
        S_LRD, S_LOUT, S_WAIT
    } state_t;

    state_t state_reg;
    logic [2:0]  act_reg;
    logic [15:0] key_reg;
    logic [31:0] qv_reg;
    logic [24:0] pv_reg;
    logic [CW-1:0] cnt_reg, pos_reg;
    logic [IW-1:0] ptr_reg;
    logic        hit_reg;
    skrt_pkg::rec_t hold_reg, found_reg;
    logic        m_valid_reg, m_last_reg;
    logic [79:0] m_data_reg;

    logic        ram_we;
    logic [IW-1:0] ram_addr;
    skrt_pkg::rec_t ram_wdata, ram_rdata;

    skrt_ram #(.WIDTH(skrt_pkg::REC_W), .DEPTH(skrt_pkg::CAPACITY)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    logic [23:0] pv_clamp;
    logic [31:0] qv_clamp;
    logic [32:0] qsum;
    logic [31:0] qsat;
    skrt_pkg::rec_t new_rec;
    logic        ins_go, del_shift;

    assign pv_clamp = pv_reg[24] ? 24'd0 : pv_reg[23:0];
    assign qv_clamp = qv_reg[31] ? 32'd0 : qv_reg;
    assign qsum = {found_reg.qty[31], found_reg.qty} + {qv_reg[31], qv_reg};
    always_comb begin
        priority if (qsum[32] != qsum[31]) begin
            qsat = qsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            qsat = qsum[31:0];
        end
    end
    assign new_rec = '{key: key_reg, qty: qv_clamp, price: pv_clamp};

    // An accepted insert writes the new record and moves any above it; a delete below the top entry moves records down.
    assign ins_go = (act_reg == skrt_pkg::ACT_INSERT) &&
                    (cnt_reg != CW'(skrt_pkg::CAPACITY)) && !hit_reg;
    assign del_shift = (act_reg == skrt_pkg::ACT_DELETE) && hit_reg &&
                       (CW'(pos_reg + 1'b1) != cnt_reg);

    always_comb begin
        ram_we = 1'b0;
        ram_addr = ptr_reg;
        ram_wdata = hold_reg;
        unique case (state_reg)
            S_IWR: ram_we = 1'b1;
            S_DWR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_DECIDE: begin
                ram_addr = pos_reg[IW-1:0];
                if (act_reg == skrt_pkg::ACT_ADDQ && hit_reg) begin
                    ram_we = 1'b1;
                    ram_wdata = '{key: found_reg.key, qty: qsat, price: found_reg.price};
                end else if (act_reg == skrt_pkg::ACT_SETP && hit_reg) begin
                    ram_we = 1'b1;
                    ram_wdata = '{key: found_reg.key, qty: found_reg.qty, price: pv_clamp};
                end
            end
            default: ;
        endcase
    end

    function automatic logic [79:0] pack_out(logic [2:0] st, skrt_pkg::rec_t r);
        pack_out = {5'd0, r.price, r.qty, r.key, st};
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        act_reg <= s_tdata[2:0];
                        qv_reg  <= s_tdata[50:19];
                        pv_reg  <= s_tdata[75:51];
                        pos_reg <= '0;
                        ptr_reg <= '0;
                        hit_reg <= 1'b0;
                        if (s_tdata[2:0] == skrt_pkg::ACT_INSERT && s_tdata[18:3] == 16'd0)
                        begin
                            key_reg <= 16'(cnt_reg + 1'b1);
                        end else begin
                            key_reg <= s_tdata[18:3];
                        end
                        priority if (s_tdata[2:0] == skrt_pkg::ACT_LIST) begin
                            if (cnt_reg == '0) begin
                                m_data_reg  <= pack_out(skrt_pkg::ST_EMPTY, '0);
                                m_last_reg  <= 1'b1;
                                m_valid_reg <= 1'b1;
                            end else begin
                                state_reg <= S_LRD;
                            end
                        end else if (s_tdata[2:0] > skrt_pkg::ACT_LIST) begin
                            state_reg <= S_IDLE;
                        end else if (cnt_reg == '0) begin
                            state_reg <= S_DECIDE;
                        end else begin
                            state_reg <= S_SRD;
                        end
                    end else if (m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_SRD: state_reg <= S_SCMP;
                S_SCMP: begin
                    // Stop at the first key not below the target.
                    if (ram_rdata.key >= key_reg) begin
                        hit_reg   <= (ram_rdata.key == key_reg);
                        found_reg <= ram_rdata;
                        state_reg <= S_DECIDE;
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                        ptr_reg <= ptr_reg + 1'b1;
                        if (CW'(pos_reg + 1'b1) == cnt_reg) begin
                            state_reg <= S_DECIDE;
                        end else begin
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_DECIDE: begin
                    m_last_reg  <= 1'b1;
                    m_valid_reg <= !(ins_go || del_shift);
                    priority if (ins_go) begin
                        state_reg <= (pos_reg == cnt_reg) ? S_IWR : S_IRD;
                    end else if (del_shift) begin
                        state_reg <= S_DRD;
                    end else begin
                        state_reg <= S_WAIT;
                    end
                    if (act_reg == skrt_pkg::ACT_INSERT) begin
                        priority if (cnt_reg == CW'(skrt_pkg::CAPACITY)) begin
                            m_data_reg <= pack_out(skrt_pkg::ST_FULL,
                                '{key: key_reg, qty: '0, price: '0});
                        end else if (hit_reg) begin
                            m_data_reg <= pack_out(skrt_pkg::ST_DUPLICATE, found_reg);
                        end else begin
                            m_data_reg <= pack_out(skrt_pkg::ST_OK, new_rec);
                            hold_reg <= new_rec;
                            ptr_reg  <= pos_reg[IW-1:0];
                            cnt_reg  <= cnt_reg + 1'b1;
                        end
                    end else if (!hit_reg) begin
                        m_data_reg <= pack_out(skrt_pkg::ST_NOT_FOUND,
                            '{key: key_reg, qty: '0, price: '0});
                    end else begin
                        unique case (act_reg)
                            skrt_pkg::ACT_ADDQ: m_data_reg <= pack_out(skrt_pkg::ST_OK,
                                '{key: found_reg.key, qty: qsat, price: found_reg.price});
                            skrt_pkg::ACT_SETP: m_data_reg <= pack_out(skrt_pkg::ST_OK,
                                '{key: found_reg.key, qty: found_reg.qty, price: pv_clamp});
                            skrt_pkg::ACT_DELETE: begin
                                m_data_reg <= pack_out(skrt_pkg::ST_OK, found_reg);
                                cnt_reg    <= cnt_reg - 1'b1;
                                if (del_shift) begin
                                    ptr_reg <= IW'(pos_reg + 1'b1);
                                end
                            end
                            default: m_data_reg <= pack_out(skrt_pkg::ST_OK, found_reg);
                        endcase
                    end
                end
                // Insert: carry the displaced record one slot up each pass.
                S_IRD: state_reg <= S_IWR;
                S_IWR: begin
                    if (CW'(ptr_reg) + 1'b1 == cnt_reg) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_WAIT;
                    end else begin
                        hold_reg  <= ram_rdata;
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_IRD;
                    end
                end
                // Delete: the record read one slot up is written straight down.
                S_DRD: begin
                    state_reg <= S_DWR;
                    ptr_reg   <= ptr_reg - 1'b1;
                end
                S_DWR: begin
                    if (CW'(ptr_reg) + 1'b1 == cnt_reg) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_WAIT;
                    end else begin
                        ptr_reg   <= IW'(ptr_reg + 2'd2);
                        state_reg <= S_DRD;
                    end
                end
                S_LRD: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                    state_reg <= S_LOUT;
                end
                S_LOUT: begin
                    if (!m_valid_reg) begin
                        m_data_reg  <= pack_out(skrt_pkg::ST_OK, ram_rdata);
                        m_last_reg  <= (CW'(ptr_reg) + 1'b1 == cnt_reg);
                        m_valid_reg <= 1'b1;
                        if (CW'(ptr_reg) + 1'b1 == cnt_reg) begin
                            state_reg <= S_WAIT;
                        end else begin
                            ptr_reg   <= ptr_reg + 1'b1;
                            state_reg <= S_LRD;
                        end
                    end else if (m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_WAIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_count_bound, aclk, aresetn, cnt_reg <= CW'(skrt_pkg::CAPACITY), "count overflow")
    `ASSERT_CLK(a_busy_no_ready, aclk, aresetn, (state_reg != S_IDLE) |-> !s_tready, "ready busy")
    `ASSERT_CLK(a_hold_out, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "unstable")
endmodule

>>> tb/sorted_keyed_record_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyed_record_table_tb
// Self-checking testbench for the sorted keyed record table.
// ----------------------------------------------------------------------------
// Actions are sent over the input stream. A behavioral copy of the sorted
// table predicts each result transfer, and every transfer on the result
// stream is checked against the oldest prediction. The tests cover directed
// corner cases, a full table, a long result stall, a sender pause and random
// traffic with idle bursts on both sides.
module sorted_keyed_record_table_tb;

    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] key;
        logic [31:0] qty;
        logic [23:0] price;
        logic        last;
    } table_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] action, [18:3] product_key, [50:19] quantity_value,
    // [75:51] price_value
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [2:0] status, [18:3] record_key, [50:19] record_quantity,
    // [74:51] record_price
    logic [79:0] m_tdata;
    logic        m_tlast;

    // Shadow copy of the table.
    logic [15:0]        shadow_key[skrt_pkg::CAPACITY];
    logic signed [31:0] shadow_qty[skrt_pkg::CAPACITY];
    logic [23:0]        shadow_price[skrt_pkg::CAPACITY];
    int                 shadow_count;

    table_result_t pending_results[$];
    int  mismatches;
    bit  idling_on;
    int  hold_cycles;
    int  quiet_cycles;

    sorted_keyed_record_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic push_result(input logic [2:0] st, input logic [15:0] k,
                               input logic [31:0] q, input logic [23:0] p,
                               input logic l);
        table_result_t r;
        r.status = st;
        r.key = k;
        r.qty = q;
        r.price = p;
        r.last = l;
        pending_results.push_back(r);
    endtask

    task automatic predict_table(input logic [2:0] act, input logic [15:0] key_in,
                                 input logic signed [31:0] qv,
                                 input logic signed [24:0] pv);
        logic [15:0] k;
        int pos;
        bit hit;
        logic signed [32:0] sum;
        logic [23:0] clamped_price;
        logic signed [31:0] removed_qty;
        logic [23:0] removed_price;
        k = key_in;
        clamped_price = pv[24] ? 24'd0 : pv[23:0];
        if (act == skrt_pkg::ACT_LIST) begin
            if (shadow_count == 0) begin
                push_result(skrt_pkg::ST_EMPTY, 16'd0, 32'd0, 24'd0, 1'b1);
            end else begin
                for (int i = 0; i < shadow_count; i++)
                    push_result(skrt_pkg::ST_OK, shadow_key[i], shadow_qty[i],
                                shadow_price[i], i == shadow_count - 1);
            end
            return;
        end
        if (act == ACT_BAD6 || act == ACT_BAD7)
            return;
        if (act == skrt_pkg::ACT_INSERT && k == 16'd0)
            k = 16'(shadow_count + 1);
        pos = 0;
        while (pos < shadow_count && shadow_key[pos] < k)
            pos++;
        hit = pos < shadow_count && shadow_key[pos] == k;

        case (act)
            skrt_pkg::ACT_INSERT: begin
                if (shadow_count >= skrt_pkg::CAPACITY) begin
                    push_result(skrt_pkg::ST_FULL, k, 32'd0, 24'd0, 1'b1);
                end else if (hit) begin
                    push_result(skrt_pkg::ST_DUPLICATE, k, shadow_qty[pos],
                                shadow_price[pos], 1'b1);
                end else begin
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_key[i] = shadow_key[i - 1];
                        shadow_qty[i] = shadow_qty[i - 1];
                        shadow_price[i] = shadow_price[i - 1];
                    end
                    shadow_key[pos] = k;
                    shadow_qty[pos] = qv < 0 ? 32'sd0 : qv;
                    shadow_price[pos] = clamped_price;
                    shadow_count++;
                    push_result(skrt_pkg::ST_OK, k, shadow_qty[pos], shadow_price[pos], 1'b1);
                end
            end
            default: begin
                if (!hit) begin
                    push_result(skrt_pkg::ST_NOT_FOUND, k, 32'd0, 24'd0, 1'b1);
                end else if (act == skrt_pkg::ACT_DELETE) begin
                    removed_qty = shadow_qty[pos];
                    removed_price = shadow_price[pos];
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_qty[i] = shadow_qty[i + 1];
                        shadow_price[i] = shadow_price[i + 1];
                    end
                    shadow_count--;
                    push_result(skrt_pkg::ST_OK, k, removed_qty, removed_price, 1'b1);
                end else begin
                    if (act == skrt_pkg::ACT_ADDQ) begin
                        sum = {shadow_qty[pos][31], shadow_qty[pos]} + {qv[31], qv};
                        // A sign disagreement between the top two bits means overflow.
                        if (sum[32] != sum[31])
                            shadow_qty[pos] = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        else
                            shadow_qty[pos] = sum[31:0];
                    end else if (act == skrt_pkg::ACT_SETP) begin
                        shadow_price[pos] = clamped_price;
                    end
                    push_result(skrt_pkg::ST_OK, k, shadow_qty[pos], shadow_price[pos], 1'b1);
                end
            end
        endcase
    endtask

    task automatic send_action(input logic [2:0] act, input logic [15:0] key,
                               input logic [31:0] qv, input logic [24:0] pv);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, pv, qv, key, act};
        do @(posedge aclk); while (!s_tready);
        predict_table(act, key, qv, pv);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // An ignored action returns the sequencer to idle at once and yields no result.
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'd0;
            default: return 16'($urandom_range(1, 90));
        endcase
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFF0 + 32'($urandom_range(0, 15));
            1:       return 32'h8000_0000 + 32'($urandom_range(0, 15));
            2:       return 32'($urandom_range(0, 1000)) - 32'd500;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_action();
        logic [2:0] act;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)      act = skrt_pkg::ACT_INSERT;
        else if (sel < 50) act = skrt_pkg::ACT_SEARCH;
        else if (sel < 62) act = skrt_pkg::ACT_ADDQ;
        else if (sel < 72) act = skrt_pkg::ACT_SETP;
        else if (sel < 92) act = skrt_pkg::ACT_DELETE;
        else if (sel < 97) act = skrt_pkg::ACT_LIST;
        else               act = sel[0] ? ACT_BAD6 : ACT_BAD7;
        send_action(act, pick_key(), pick_qty(), 25'($urandom()));
    endtask

    task automatic test_directed();
        send_action(skrt_pkg::ACT_LIST, 16'd0, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_INSERT, 16'd0, 32'd5, 25'd100);
        send_action(skrt_pkg::ACT_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 25'h0FF_FFFF);
        send_action(skrt_pkg::ACT_INSERT, 16'd10, 32'h8000_0000, 25'h100_0000);
        send_action(skrt_pkg::ACT_INSERT, 16'd0, 32'd1, 25'd1);
        send_action(skrt_pkg::ACT_INSERT, 16'd0, 32'd9, 25'd9);
        send_action(skrt_pkg::ACT_INSERT, 16'd10, 32'd3, 25'd3);
        send_action(skrt_pkg::ACT_SEARCH, 16'hFFFF, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_SEARCH, 16'd7, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_ADDQ, 16'hFFFF, 32'd1, 25'd0);
        send_action(skrt_pkg::ACT_ADDQ, 16'd1, 32'h8000_0000, 25'd0);
        send_action(skrt_pkg::ACT_ADDQ, 16'd1, 32'h8000_0000, 25'd0);
        send_action(skrt_pkg::ACT_ADDQ, 16'd1, 32'hFFFF_FFFE, 25'd0);
        send_action(skrt_pkg::ACT_ADDQ, 16'd8, 32'd1, 25'd0);
        send_action(skrt_pkg::ACT_SETP, 16'd10, 32'd0, 25'h1FF_FFFF);
        send_action(skrt_pkg::ACT_SETP, 16'd1, 32'd0, 25'h0FF_FFFF);
        send_action(skrt_pkg::ACT_SETP, 16'd3, 32'd0, 25'd1);
        send_action(ACT_BAD6, 16'd1, 32'd0, 25'd0);
        send_action(ACT_BAD7, 16'd1, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_LIST, 16'd0, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_DELETE, 16'd2, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_DELETE, 16'd2, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_DELETE, 16'd0, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_LIST, 16'd0, 32'd0, 25'd0);
        wait_for_results();
    endtask

    task automatic test_full_table();
        while (shadow_count < skrt_pkg::CAPACITY)
            send_action(skrt_pkg::ACT_INSERT, 16'($urandom_range(0, 65535)), $urandom(),
                        25'($urandom()));
        send_action(skrt_pkg::ACT_INSERT, 16'd0, 32'd1, 25'd1);
        send_action(skrt_pkg::ACT_INSERT, shadow_key[5], 32'd1, 25'd1);
        send_action(skrt_pkg::ACT_LIST, 16'd0, 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_SEARCH, shadow_key[skrt_pkg::CAPACITY - 1], 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_DELETE, shadow_key[skrt_pkg::CAPACITY - 1], 32'd0, 25'd0);
        send_action(skrt_pkg::ACT_DELETE, shadow_key[0], 32'd0, 25'd0);
        while (shadow_count > 0)
            send_action(skrt_pkg::ACT_DELETE,
                        shadow_key[$urandom_range(0, shadow_count - 1)], 32'd0, 25'd0);
        wait_for_results();
    endtask

    task automatic test_result_stall();
        hold_cycles = 400;
        repeat (20) send_random_action();
        send_action(skrt_pkg::ACT_LIST, 16'd0, 32'd0, 25'd0);
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            // The sender stops now and then until the table has caught up.
            if (n % 150 == 75)
                wait_for_results();
            send_random_action();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        idling_on = 1'b0;
        hold_cycles = 0;
        shadow_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        idling_on = 1'b1;
        test_result_stall();
        test_random_traffic(250);
        idling_on = 1'b0;
        test_random_traffic(60);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: random stalls and the long hold-off, counted here.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %h last %b", m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status || m_tdata[18:3] !== want.key ||
                    m_tdata[50:19] !== want.qty || m_tdata[74:51] !== want.price ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected st %0d key %h qty %h price %h last %b,",
                                  " got st %0d key %h qty %h price %h last %b"},
                                 want.status, want.key, want.qty, want.price, want.last,
                                 m_tdata[2:0], m_tdata[18:3], m_tdata[50:19],
                                 m_tdata[74:51], m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end
endmodule
